// ===== rtl/fndc_pkg.sv =====
package fndc_pkg;

  // Field and datapath widths.
  localparam int FREQ_W = 23;
  localparam int DIV_W  = 18;
  localparam int QN_W   = 23;
  localparam int QF_W   = 25;
  localparam int DEN_W  = 25;
  localparam int PROD_W = DIV_W + DEN_W;
  localparam int N_W    = 16;
  localparam int NUM_W  = 24;
  localparam int CODE_W = 4;
  localparam int PFD_W  = 18;

  // Legal VCO window in kHz; both limits are exclusive.
  localparam logic [31:0] VCO_LOW_KHZ  = 32'd4300000;
  localparam logic [31:0] VCO_HIGH_KHZ = 32'd5376000;

  // Channel table of the internal path.
  localparam logic [FREQ_W-1:0] CH_A0_KHZ = 23'd28350;
  localparam logic [FREQ_W-1:0] CH_A1_KHZ = 23'd29925;
  localparam logic [FREQ_W-1:0] CH_B0_KHZ = 23'd31500;
  localparam logic [FREQ_W-1:0] CH_B1_KHZ = 23'd38250;
  localparam logic [FREQ_W-1:0] CH_B2_KHZ = 23'd39375;

  // Divisors already include the prescaler of two.
  localparam logic [DIV_W-1:0] DIVISOR_A = 18'd201600;
  localparam logic [DIV_W-1:0] DIVISOR_B = 18'd151200;
  localparam logic [DIV_W-1:0] DIVISOR_C = 18'd126000;

  localparam logic [CODE_W-1:0] PUMP_A = 4'd5;
  localparam logic [CODE_W-1:0] PUMP_B = 4'd7;
  localparam logic [CODE_W-1:0] PUMP_C = 4'd8;
  localparam logic [CODE_W-1:0] MULT_A = 4'd8;
  localparam logic [CODE_W-1:0] MULT_B = 4'd6;
  localparam logic [CODE_W-1:0] MULT_C = 4'd5;

  localparam logic [DEN_W-1:0] DEN_RESET = 25'd1048576;
  localparam logic [PFD_W-1:0] PFD_RESET = 18'd4200;

  typedef enum logic [0:0] {
    CFG_FRAC_DEN = 1'b0,
    CFG_EXT_PFD  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [FREQ_W-1:0] freq_khz;
    logic              internal_vco;
  } in_t;

  typedef struct packed {
    logic              valid_res;
    logic [1:0]        div1_index;
    logic [2:0]        div2_index;
    logic [N_W-1:0]    n_integer;
    logic [NUM_W-1:0]  frac_numerator;
    logic [7:0]        den_high;
    logic [15:0]       den_low;
    logic [CODE_W-1:0] pump_current_code;
    logic [CODE_W-1:0] multiplier_code;
  } out_t;

  typedef struct packed {
    logic              found;
    logic [1:0]        div1_idx;
    logic [2:0]        div2_idx;
    logic [QN_W-1:0]   vco;
    logic [DIV_W-1:0]  divisor;
    logic [CODE_W-1:0] pump;
    logic [CODE_W-1:0] mult;
  } prep_t;

  typedef struct packed {
    logic              found;
    logic [1:0]        div1_idx;
    logic [2:0]        div2_idx;
    logic [CODE_W-1:0] pump;
    logic [CODE_W-1:0] mult;
  } side1_t;

  typedef struct packed {
    logic              ok;
    logic [1:0]        div1_idx;
    logic [2:0]        div2_idx;
    logic [N_W-1:0]    n;
    logic [CODE_W-1:0] pump;
    logic [CODE_W-1:0] mult;
  } side2_t;

endpackage

// ===== rtl/fractional_n_divider_calc_core.sv =====
// Fractional-N divider calculation. A request is taken in every clock cycle
// (busy_o never rises) and its settings appear on result_o, marked by a
// one-cycle done_o strobe, in request order.
// The pipeline is made of the two restoring-division chains: one cell per
// quotient bit, 23 cells for the integer part and 25 for the fractional
// numerator, plus the divider-pair search stage, the 18 x 25 bit multiplier
// stage between the chains and the output register. Results must be taken
// when they appear. Configuration writes take effect at once and are meant
// for times when no request is in flight.
module fractional_n_divider_calc_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  fndc_pkg::in_t              item_i,
  output logic                       busy_o,
  output logic                       done_o,
  output fndc_pkg::out_t             result_o,
  input  logic                       cfg_we_i,
  input  fndc_pkg::cfg_idx_e         cfg_idx_i,
  input  logic [fndc_pkg::DEN_W-1:0] cfg_data_i
);

  localparam int DW    = fndc_pkg::DIV_W;
  localparam int QNW   = fndc_pkg::QN_W;
  localparam int QFW   = fndc_pkg::QF_W;
  localparam int NW    = fndc_pkg::N_W;
  localparam int NUMW  = fndc_pkg::NUM_W;
  localparam int DENW  = fndc_pkg::DEN_W;
  localparam int PRODW = fndc_pkg::PROD_W;
  localparam int PFDW  = fndc_pkg::PFD_W;

  logic [DENW-1:0] den_q;
  logic [PFDW-1:0] pfd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      den_q <= fndc_pkg::DEN_RESET;
      pfd_q <= fndc_pkg::PFD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fndc_pkg::CFG_FRAC_DEN: den_q <= cfg_data_i;
        fndc_pkg::CFG_EXT_PFD:  pfd_q <= cfg_data_i[PFDW-1:0];
        default:                den_q <= den_q;
      endcase
    end
  end

  assign busy_o = 1'b0;

  logic            prep_valid;
  fndc_pkg::prep_t prep;

  fndc_search u_search (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (start_i && !busy_o),
    .item_i    (item_i),
    .ext_pfd_i (pfd_q),
    .valid_o   (prep_valid),
    .prep_o    (prep)
  );

  // Integer chain: vco / divisor.
  logic             c1_valid [0:QNW];
  logic [DW-1:0]    c1_rem   [0:QNW];
  logic [DW-1:0]    c1_div   [0:QNW];
  logic [QNW-1:0]   c1_bits  [0:QNW];
  fndc_pkg::side1_t c1_side  [0:QNW];

  assign c1_valid[0]          = prep_valid;
  assign c1_rem[0]            = '0;
  assign c1_div[0]            = prep.divisor;
  assign c1_bits[0]           = prep.vco;
  assign c1_side[0].found     = prep.found;
  assign c1_side[0].div1_idx  = prep.div1_idx;
  assign c1_side[0].div2_idx  = prep.div2_idx;
  assign c1_side[0].pump      = prep.pump;
  assign c1_side[0].mult      = prep.mult;

  for (genvar k = 0; k < QNW; k++) begin : g_int
    fndc_cell #(
      .W      (QNW),
      .side_t (fndc_pkg::side1_t)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (c1_valid[k]),
      .rem_i   (c1_rem[k]),
      .div_i   (c1_div[k]),
      .bits_i  (c1_bits[k]),
      .side_i  (c1_side[k]),
      .valid_o (c1_valid[k+1]),
      .rem_o   (c1_rem[k+1]),
      .div_o   (c1_div[k+1]),
      .bits_o  (c1_bits[k+1]),
      .side_o  (c1_side[k+1])
    );
  end

  // Remainder times denominator, registered before the fractional chain.
  logic             n_fits;
  fndc_pkg::side2_t side2_d;
  logic [PRODW-1:0] prod_d;
  logic             mult_valid_q;
  logic [PRODW-1:0] mult_prod_q;
  logic [DW-1:0]    mult_div_q;
  fndc_pkg::side2_t mult_side_q;

  assign n_fits           = c1_bits[QNW][QNW-1:NW] == '0;
  assign side2_d.ok       = c1_side[QNW].found && n_fits;
  assign side2_d.div1_idx = c1_side[QNW].div1_idx;
  assign side2_d.div2_idx = c1_side[QNW].div2_idx;
  assign side2_d.n        = c1_bits[QNW][NW-1:0];
  assign side2_d.pump     = c1_side[QNW].pump;
  assign side2_d.mult     = c1_side[QNW].mult;
  assign prod_d           = PRODW'(c1_rem[QNW]) * PRODW'(den_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_valid_q <= 1'b0;
    end else begin
      mult_valid_q <= c1_valid[QNW];
    end
  end

  always_ff @(posedge clk_i) begin
    mult_prod_q <= prod_d;
    mult_div_q  <= c1_div[QNW];
    mult_side_q <= side2_d;
  end

  // Fractional chain. The product is below divisor * 2^25, so its upper bits
  // already form a remainder smaller than the divisor.
  logic             c2_valid [0:QFW];
  logic [DW-1:0]    c2_rem   [0:QFW];
  logic [DW-1:0]    c2_div   [0:QFW];
  logic [QFW-1:0]   c2_bits  [0:QFW];
  fndc_pkg::side2_t c2_side  [0:QFW];

  assign c2_valid[0] = mult_valid_q;
  assign c2_rem[0]   = mult_prod_q[PRODW-1:QFW];
  assign c2_div[0]   = mult_div_q;
  assign c2_bits[0]  = mult_prod_q[QFW-1:0];
  assign c2_side[0]  = mult_side_q;

  for (genvar k = 0; k < QFW; k++) begin : g_frac
    fndc_cell #(
      .W      (QFW),
      .side_t (fndc_pkg::side2_t)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (c2_valid[k]),
      .rem_i   (c2_rem[k]),
      .div_i   (c2_div[k]),
      .bits_i  (c2_bits[k]),
      .side_i  (c2_side[k]),
      .valid_o (c2_valid[k+1]),
      .rem_o   (c2_rem[k+1]),
      .div_o   (c2_div[k+1]),
      .bits_o  (c2_bits[k+1]),
      .side_o  (c2_side[k+1])
    );
  end

  logic [DENW-17:0] den_hi;
  logic [DENW-17:0] den_hi_m1;
  logic [NUMW-1:0]  frac_sat;
  fndc_pkg::out_t   out_d;
  fndc_pkg::out_t   out_q;
  logic             done_q;

  assign den_hi    = den_q[DENW-1:16];
  assign den_hi_m1 = den_hi - (DENW - 16)'(1);
  assign frac_sat  = (c2_bits[QFW][QFW-1:NUMW] != '0) ? '1 : c2_bits[QFW][NUMW-1:0];

  always_comb begin
    out_d                   = '0;
    out_d.valid_res         = c2_side[QFW].ok;
    out_d.div1_index        = c2_side[QFW].div1_idx;
    out_d.div2_index        = c2_side[QFW].div2_idx;
    out_d.pump_current_code = c2_side[QFW].pump;
    out_d.multiplier_code   = c2_side[QFW].mult;
    if (c2_side[QFW].ok) begin
      out_d.n_integer      = c2_side[QFW].n;
      out_d.frac_numerator = frac_sat;
    end
    if (den_hi == '0) begin
      out_d.den_low = den_q[15:0];
    end else begin
      out_d.den_low  = '1;
      out_d.den_high = den_hi_m1[DENW-17] ? '1 : den_hi_m1[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= c2_valid[QFW];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign done_o   = done_q;
  assign result_o = out_q;

  // A request with no usable ratio must not leak stale quotient bits.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !result_o.valid_res |->
      result_o.n_integer == '0 && result_o.frac_numerator == '0)
    else $error("invalid result carries a non-zero ratio");

  // The numerator is a fraction of the denominator.
  a_frac_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.valid_res && den_q != '0 && !den_q[DENW-1] |->
      DENW'(result_o.frac_numerator) < den_q)
    else $error("fractional numerator not below denominator");

  // A divider pair chosen on the internal path lies inside the VCO window.
  a_vco_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prep_valid && prep.found && prep.pump != '0 |->
      32'(prep.vco) > fndc_pkg::VCO_LOW_KHZ && 32'(prep.vco) < fndc_pkg::VCO_HIGH_KHZ)
    else $error("selected VCO frequency outside the window");

  // The strobe follows a valid item leaving the fractional chain.
  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c2_valid[QFW] |=> done_o)
    else $error("result lost at the output register");

endmodule

// ===== rtl/fndc_cell.sv =====
module fndc_cell #(
  parameter int  W      = 23,
  parameter type side_t = logic
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [fndc_pkg::DIV_W-1:0] rem_i,
  input  logic [fndc_pkg::DIV_W-1:0] div_i,
  input  logic [W-1:0]             bits_i,
  input  side_t                    side_i,
  output logic                     valid_o,
  output logic [fndc_pkg::DIV_W-1:0] rem_o,
  output logic [fndc_pkg::DIV_W-1:0] div_o,
  output logic [W-1:0]             bits_o,
  output side_t                    side_o
);

  localparam int DW = fndc_pkg::DIV_W;

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_d;
  logic [W-1:0]  bits_d;

  logic          valid_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] div_q;
  logic [W-1:0]  bits_q;
  side_t         side_q;

  // One restoring step: bring in the next dividend bit and try a subtract.
  // The dividend bits leave at the top while quotient bits enter at the bottom.
  assign trial  = {rem_i, bits_i[W-1]};
  assign diff   = trial - {1'b0, div_i};
  assign ge     = trial >= {1'b0, div_i};
  assign rem_d  = ge ? diff[DW-1:0] : trial[DW-1:0];
  assign bits_d = {bits_i[W-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    div_q  <= div_i;
    bits_q <= bits_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign div_o   = div_q;
  assign bits_o  = bits_q;
  assign side_o  = side_q;

endmodule

// ===== rtl/fndc_search.sv =====
module fndc_search (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  fndc_pkg::in_t              item_i,
  input  logic [fndc_pkg::PFD_W-1:0] ext_pfd_i,
  output logic                       valid_o,
  output fndc_pkg::prep_t            prep_o
);

  localparam int MW = 26;

  logic [MW-1:0]   prod1 [4];
  logic [31:0]     vco_try [7][4];
  logic            hit [7][4];
  fndc_pkg::prep_t prep_d;
  logic            valid_q;
  fndc_pkg::prep_t prep_q;

  // All 28 divider pairs are tried side by side; d2 is a power of two, so
  // each candidate is d1 * freq shifted left.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod1[i] = MW'(item_i.freq_khz) * MW'(i + 4);
      for (int j = 0; j < 7; j++) begin
        vco_try[j][i] = 32'(prod1[i]) << j;
        hit[j][i] = (vco_try[j][i] > fndc_pkg::VCO_LOW_KHZ) &&
                    (vco_try[j][i] < fndc_pkg::VCO_HIGH_KHZ);
      end
    end
  end

  always_comb begin
    prep_d = '0;
    if (item_i.internal_vco) begin
      unique if (item_i.freq_khz == fndc_pkg::CH_A0_KHZ ||
                 item_i.freq_khz == fndc_pkg::CH_A1_KHZ) begin
        prep_d.divisor = fndc_pkg::DIVISOR_A;
        prep_d.pump    = fndc_pkg::PUMP_A;
        prep_d.mult    = fndc_pkg::MULT_A;
      end else if (item_i.freq_khz == fndc_pkg::CH_B0_KHZ ||
                   item_i.freq_khz == fndc_pkg::CH_B1_KHZ ||
                   item_i.freq_khz == fndc_pkg::CH_B2_KHZ) begin
        prep_d.divisor = fndc_pkg::DIVISOR_B;
        prep_d.pump    = fndc_pkg::PUMP_B;
        prep_d.mult    = fndc_pkg::MULT_B;
      end else begin
        prep_d.divisor = fndc_pkg::DIVISOR_C;
        prep_d.pump    = fndc_pkg::PUMP_C;
        prep_d.mult    = fndc_pkg::MULT_C;
      end
      // The second divider is the outer search loop, so it ranks first.
      for (int j = 0; j < 7; j++) begin
        for (int i = 0; i < 4; i++) begin
          if (!prep_d.found && hit[j][i]) begin
            prep_d.found    = 1'b1;
            prep_d.div1_idx = 2'(i);
            prep_d.div2_idx = 3'(j);
            prep_d.vco      = vco_try[j][i][fndc_pkg::QN_W-1:0];
          end
        end
      end
    end else begin
      prep_d.vco     = item_i.freq_khz;
      prep_d.divisor = ext_pfd_i;
      prep_d.found   = ext_pfd_i != '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prep_q <= prep_d;
  end

  assign valid_o = valid_q;
  assign prep_o  = prep_q;

endmodule
